FILE: rtl/rms_pkg.sv
`default_nettype none

package rms_pkg;

  // walking gait count default
  localparam int unsigned WALKING_GAITS_DEF = 3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_OFF_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TIMEOUT    = 2'd2;

  localparam logic [15:0] TORQUE_OFF_WAIT_RST = 16'd60000;
  localparam logic [15:0] IDLE_TIMEOUT_RST    = 16'd15000;
  localparam logic [15:0] DATA_TIMEOUT_RST    = 16'd250;

  localparam logic [4:0]  MAX_TICK_MS       = 5'd20;
  localparam logic [16:0] TIMER_MAX         = 17'd131071;
  localparam logic [11:0] PARK_MS           = 12'd3000;
  localparam logic [11:0] STAND_PARKED_MS   = 12'd3000;
  localparam logic [11:0] STAND_DEPLOYED_MS = 12'd1000;

  // mode codes as seen on the result channel
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_INIT  = 3'd1;
  localparam logic [2:0] MODE_READY = 3'd2;
  localparam logic [2:0] MODE_STAND = 3'd3;
  localparam logic [2:0] MODE_LEVEL = 3'd4;
  localparam logic [2:0] MODE_POSE  = 3'd5;
  localparam logic [2:0] MODE_WALK  = 3'd6;

  typedef enum logic [6:0] {
    ST_OFF   = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_READY = 7'b0000100,
    ST_STAND = 7'b0001000,
    ST_LEVEL = 7'b0010000,
    ST_POSE  = 7'b0100000,
    ST_WALK  = 7'b1000000
  } mode_state_e;

  typedef enum logic [2:0] {
    GAIT_NONE    = 3'd0,
    GAIT_PARK    = 3'd1,
    GAIT_STANDUP = 3'd2,
    GAIT_POSING  = 3'd3,
    GAIT_LEVEL   = 3'd4,
    GAIT_WALK    = 3'd5
  } gait_req_e;

  typedef enum logic [1:0] {
    SOUND_NONE     = 2'd0,
    SOUND_STARTUP  = 2'd1,
    SOUND_SHUTDOWN = 2'd2
  } sound_e;

  typedef struct packed {
    logic [15:0] torque_off_wait_ms;
    logic [15:0] idle_timeout_ms;
    logic [15:0] data_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  elapsed_ms;
    logic        power_switch_on;
    logic        link_paired;
    logic [15:0] data_age_ms;
    logic        gait_ready;
    logic        all_torque_on;
    logic        new_command;
    logic        button_left;
    logic        button_right;
    logic [2:0]  mode_switches;
    logic        axes_active;
  } item_t;

  typedef struct packed {
    logic axes;
    logic balance;
    logic pose;
    logic adjust;
    logic right;
    logic left;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  mode;
    gait_req_e   gait_request;
    logic [11:0] gait_duration_ms;
    logic [1:0]  walking_gait;
    logic        torque_off;
    sound_e      sound_cue;
    logic        reset_gait_params;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_state_e st);
    logic [2:0] code;
    unique case (st)
      ST_OFF:   code = MODE_OFF;
      ST_INIT:  code = MODE_INIT;
      ST_READY: code = MODE_READY;
      ST_STAND: code = MODE_STAND;
      ST_LEVEL: code = MODE_LEVEL;
      ST_POSE:  code = MODE_POSE;
      ST_WALK:  code = MODE_WALK;
      default:  code = MODE_READY;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rms_cfg_regs.sv
`default_nettype none

module rms_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [15:0]                    cfg_wdata_i,
  output rms_pkg::cfg_t                       cfg_o
);

  rms_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.torque_off_wait_ms <= rms_pkg::TORQUE_OFF_WAIT_RST;
      cfg_q.idle_timeout_ms    <= rms_pkg::IDLE_TIMEOUT_RST;
      cfg_q.data_timeout_ms    <= rms_pkg::DATA_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rms_pkg::CFG_TORQUE_OFF_WAIT: cfg_q.torque_off_wait_ms <= cfg_wdata_i;
        rms_pkg::CFG_IDLE_TIMEOUT:    cfg_q.idle_timeout_ms    <= cfg_wdata_i;
        rms_pkg::CFG_DATA_TIMEOUT:    cfg_q.data_timeout_ms    <= cfg_wdata_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/rms_in_stage.sv
`default_nettype none

module rms_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire logic           drain_i,
  input  wire rms_pkg::item_t item_i,
  output logic                valid_o,
  output rms_pkg::item_t      item_o
);

  logic           valid_q, valid_d;
  rms_pkg::item_t item_q;

  // load wins over drain: a drained slot refills in the same cycle
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: rtl/rms_core.sv
`default_nettype none

module rms_core #(
  parameter int unsigned WALKING_GAITS = rms_pkg::WALKING_GAITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire rms_pkg::cfg_t  cfg_i,
  input  wire rms_pkg::item_t item_i,
  output rms_pkg::result_t    res_o
);

  localparam logic [2:0] GaitCnt = 3'(WALKING_GAITS);

  rms_pkg::mode_state_e mode_q, mode_d;
  logic [16:0]          time_q, time_d;
  rms_pkg::cmd_t        cmd_q, cmd_d;
  logic [1:0]           gi_q, gi_d;

  logic [4:0]           dt;
  logic [17:0]          sum;
  logic [16:0]          t_acc;
  logic [16:0]          t_walk;
  logic [1:0]           gi;
  logic [2:0]           gi_inc;
  rms_pkg::cmd_t        lc;
  logic                 unhealthy;
  logic [16:0]          idle2;
  logic [16:0]          wait_lim;
  logic [16:0]          idle_lim;
  rms_pkg::gait_req_e   req;
  logic [11:0]          dur;
  logic                 torque;
  rms_pkg::sound_e      sound;
  logic                 prst;

  always_comb begin
    dt     = (item_i.elapsed_ms > rms_pkg::MAX_TICK_MS) ? rms_pkg::MAX_TICK_MS
                                                        : item_i.elapsed_ms;
    sum    = {1'b0, time_q} + {13'd0, dt};
    t_acc  = sum[17] ? rms_pkg::TIMER_MAX : sum[16:0];
    gi     = ({1'b0, gi_q} >= GaitCnt) ? 2'd0 : gi_q;
    gi_inc = {1'b0, gi} + 3'd1;

    if (item_i.new_command) begin
      lc = '{axes:    item_i.axes_active,
             balance: item_i.mode_switches[2],
             pose:    item_i.mode_switches[1],
             adjust:  item_i.mode_switches[0],
             right:   item_i.button_right,
             left:    item_i.button_left};
    end else begin
      lc = cmd_q;
    end

    unhealthy = !(item_i.link_paired && (item_i.data_age_ms <= cfg_i.data_timeout_ms))
                || !item_i.power_switch_on;
    idle2    = {cfg_i.idle_timeout_ms, 1'b0};
    wait_lim = {1'b0, cfg_i.torque_off_wait_ms};
    idle_lim = {1'b0, cfg_i.idle_timeout_ms};
    t_walk   = lc.axes ? 17'd0 : t_acc;

    mode_d = mode_q;
    time_d = t_acc;
    cmd_d  = lc;
    gi_d   = gi;
    req    = rms_pkg::GAIT_NONE;
    dur    = 12'd0;
    torque = 1'b0;
    sound  = rms_pkg::SOUND_NONE;
    prst   = 1'b0;

    unique case (mode_q)
      rms_pkg::ST_OFF: begin
        if (item_i.power_switch_on) begin
          sound  = rms_pkg::SOUND_STARTUP;
          req    = rms_pkg::GAIT_PARK;
          dur    = rms_pkg::PARK_MS;
          mode_d = rms_pkg::ST_INIT;
          time_d = 17'd0;
          prst   = 1'b1;
        end
      end
      rms_pkg::ST_INIT: begin
        if (item_i.gait_ready) begin
          if (!item_i.power_switch_on) begin
            torque = 1'b1;
            sound  = rms_pkg::SOUND_SHUTDOWN;
            mode_d = rms_pkg::ST_OFF;
            time_d = 17'd0;
          end else if (item_i.link_paired) begin
            if (!item_i.all_torque_on) begin
              req = rms_pkg::GAIT_PARK;
              dur = rms_pkg::PARK_MS;
            end
            mode_d = rms_pkg::ST_READY;
            time_d = 17'd0;
          end else if (t_acc > wait_lim) begin
            time_d = 17'd0;
            torque = 1'b1;
          end
        end
      end
      rms_pkg::ST_READY: begin
        if (unhealthy) begin
          cmd_d  = '0;
          mode_d = rms_pkg::ST_INIT;
          time_d = 17'd0;
          prst   = 1'b1;
        end else if (lc.left && item_i.gait_ready) begin
          cmd_d.left = 1'b0;
          req    = rms_pkg::GAIT_STANDUP;
          dur    = rms_pkg::STAND_PARKED_MS;
          mode_d = rms_pkg::ST_STAND;
          time_d = 17'd0;
        end else if (t_acc > wait_lim) begin
          time_d = 17'd0;
          torque = 1'b1;
        end
      end
      rms_pkg::ST_STAND: begin
        if (item_i.gait_ready) begin
          if (unhealthy) begin
            cmd_d  = '0;
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_INIT;
            time_d = 17'd0;
            prst   = 1'b1;
          end else if (lc.pose) begin
            req    = rms_pkg::GAIT_POSING;
            mode_d = rms_pkg::ST_POSE;
            time_d = 17'd0;
          end else if (lc.balance) begin
            req    = rms_pkg::GAIT_LEVEL;
            mode_d = rms_pkg::ST_LEVEL;
            time_d = 17'd0;
          end else if (lc.left) begin
            cmd_d.left = 1'b0;
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_READY;
            time_d = 17'd0;
          end else if (lc.axes || lc.right || lc.adjust) begin
            req    = rms_pkg::GAIT_WALK;
            mode_d = rms_pkg::ST_WALK;
            time_d = 17'd0;
          end else if (t_acc > idle2) begin
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_READY;
            time_d = 17'd0;
          end
        end
      end
      rms_pkg::ST_LEVEL: begin
        if (item_i.gait_ready) begin
          if (unhealthy) begin
            cmd_d  = '0;
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_INIT;
            time_d = 17'd0;
            prst   = 1'b1;
          end else if (lc.left) begin
            cmd_d.left = 1'b0;
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_READY;
            time_d = 17'd0;
          end else if (lc.pose) begin
            req    = rms_pkg::GAIT_POSING;
            mode_d = rms_pkg::ST_POSE;
            time_d = 17'd0;
          end else if (!lc.balance) begin
            req    = rms_pkg::GAIT_STANDUP;
            dur    = rms_pkg::STAND_DEPLOYED_MS;
            mode_d = rms_pkg::ST_STAND;
            time_d = 17'd0;
          end
        end
      end
      rms_pkg::ST_POSE: begin
        if (item_i.gait_ready) begin
          if (unhealthy) begin
            cmd_d  = '0;
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_INIT;
            time_d = 17'd0;
            prst   = 1'b1;
          end else if (lc.left) begin
            cmd_d.left = 1'b0;
            req    = rms_pkg::GAIT_PARK;
            dur    = rms_pkg::PARK_MS;
            mode_d = rms_pkg::ST_READY;
            time_d = 17'd0;
          end else if (!lc.pose) begin
            req    = rms_pkg::GAIT_STANDUP;
            dur    = rms_pkg::STAND_DEPLOYED_MS;
            mode_d = rms_pkg::ST_STAND;
            time_d = 17'd0;
          end
        end
      end
      rms_pkg::ST_WALK: begin
        // joystick activity keeps the idle timer at zero
        time_d = t_walk;
        if (unhealthy) begin
          cmd_d  = '0;
          req    = rms_pkg::GAIT_PARK;
          dur    = rms_pkg::PARK_MS;
          mode_d = rms_pkg::ST_INIT;
          time_d = 17'd0;
          prst   = 1'b1;
        end else if (lc.left) begin
          cmd_d.left = 1'b0;
          req    = rms_pkg::GAIT_PARK;
          dur    = rms_pkg::PARK_MS;
          mode_d = rms_pkg::ST_READY;
          time_d = 17'd0;
        end else if (lc.right) begin
          cmd_d.right = 1'b0;
          gi_d   = (gi_inc >= GaitCnt) ? 2'd0 : gi_inc[1:0];
          time_d = 17'd0;
          req    = rms_pkg::GAIT_WALK;
        end else if (lc.pose) begin
          req    = rms_pkg::GAIT_POSING;
          mode_d = rms_pkg::ST_POSE;
          time_d = 17'd0;
        end else if (lc.balance) begin
          req    = rms_pkg::GAIT_LEVEL;
          mode_d = rms_pkg::ST_LEVEL;
          time_d = 17'd0;
        end else if (t_walk > idle_lim) begin
          req    = rms_pkg::GAIT_STANDUP;
          dur    = rms_pkg::STAND_DEPLOYED_MS;
          mode_d = rms_pkg::ST_STAND;
          time_d = 17'd0;
        end
      end
      default: begin
        // corrupted mode: park and fall back to ready
        req    = rms_pkg::GAIT_PARK;
        dur    = rms_pkg::PARK_MS;
        mode_d = rms_pkg::ST_READY;
        time_d = 17'd0;
      end
    endcase

    res_o.mode              = rms_pkg::mode_code(mode_d);
    res_o.gait_request      = req;
    res_o.gait_duration_ms  = dur;
    res_o.walking_gait      = (req == rms_pkg::GAIT_WALK) ? gi_d : 2'd0;
    res_o.torque_off        = torque;
    res_o.sound_cue         = sound;
    res_o.reset_gait_params = prst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rms_pkg::ST_OFF;
      time_q <= 17'd0;
      cmd_q  <= '0;
      gi_q   <= 2'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      time_q <= time_d;
      cmd_q  <= cmd_d;
      gi_q   <= gi_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/robot_mode_supervisor.sv
// robot mode supervisor: one control tick in, one result out
//
// input channel: in_valid_i / in_stall_o with one port per tick field; a transfer
// happens on a rising edge with valid high and stall low
// result channel: out_valid_o / out_stall_i with one port per result field
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 torque-off wait, 1 idle timeout, 2 data timeout); other indexes are ignored
//
// a transferred tick is registered in the input stage, evaluated against the mode
// state and captured in the result register, which drives the result port
// throughput: one tick per cycle while the result channel is not stalled, set by
// the single evaluation stage between the input register and the result register
//
// reset: mode off, timer and latched command cleared, gait index 0, registers at
// their defaults, both channels empty
// a stalled result holds its value; the input register still takes one more tick,
// then in_stall_o rises until the result is taken
`default_nettype none

module robot_mode_supervisor #(
  parameter int unsigned WALKING_GAITS = rms_pkg::WALKING_GAITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [rms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  // tick input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [4:0]                    elapsed_ms_i,
  input  wire logic                          power_switch_on_i,
  input  wire logic                          link_paired_i,
  input  wire logic [15:0]                   data_age_ms_i,
  input  wire logic                          gait_ready_i,
  input  wire logic                          all_torque_on_i,
  input  wire logic                          new_command_i,
  input  wire logic                          button_left_i,
  input  wire logic                          button_right_i,
  input  wire logic [2:0]                    mode_switches_i,
  input  wire logic                          axes_active_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         mode_o,
  output logic [2:0]                         gait_request_o,
  output logic [11:0]                        gait_duration_ms_o,
  output logic [1:0]                         walking_gait_o,
  output logic                               torque_off_o,
  output logic [1:0]                         sound_cue_o,
  output logic                               reset_gait_params_o
);

  rms_pkg::cfg_t    cfg;
  rms_pkg::item_t   in_item;
  rms_pkg::item_t   s1_item;
  rms_pkg::result_t res;
  rms_pkg::result_t out_q;
  logic             s1_valid;
  logic             in_xfer;
  logic             advance;
  logic             out_valid_q, out_valid_d;

  rms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_item = '{elapsed_ms:      elapsed_ms_i,
                     power_switch_on: power_switch_on_i,
                     link_paired:     link_paired_i,
                     data_age_ms:     data_age_ms_i,
                     gait_ready:      gait_ready_i,
                     all_torque_on:   all_torque_on_i,
                     new_command:     new_command_i,
                     button_left:     button_left_i,
                     button_right:    button_right_i,
                     mode_switches:   mode_switches_i,
                     axes_active:     axes_active_i};

  // the registered tick moves on whenever the result register is free or being taken
  assign advance    = s1_valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  rms_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_xfer),
    .drain_i (advance),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  // mode state advances exactly once per tick, when its result is captured
  rms_core #(
    .WALKING_GAITS (WALKING_GAITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .item_i (s1_item),
    .res_o  (res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_o              = out_q.mode;
  assign gait_request_o      = out_q.gait_request;
  assign gait_duration_ms_o  = out_q.gait_duration_ms;
  assign walking_gait_o      = out_q.walking_gait;
  assign torque_off_o        = out_q.torque_off;
  assign sound_cue_o         = out_q.sound_cue;
  assign reset_gait_params_o = out_q.reset_gait_params;

endmodule

`default_nettype wire

FILE: rtl/rms_checker.sv
`default_nettype none

module rms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  mode_o,
  input wire logic [2:0]  gait_request_o,
  input wire logic [11:0] gait_duration_ms_o,
  input wire logic [1:0]  walking_gait_o,
  input wire logic [1:0]  sound_cue_o,
  input wire logic        reset_gait_params_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o)
      && $stable(gait_request_o) && $stable(gait_duration_ms_o))
    else $error("stalled result changed");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mode_o != 3'd7)
    else $error("illegal mode code");

  a_reset_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_gait_params_o |-> mode_o == rms_pkg::MODE_INIT)
    else $error("parameter reset outside initializing");

  a_startup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sound_cue_o == rms_pkg::SOUND_STARTUP)
      |-> (mode_o == rms_pkg::MODE_INIT) && (gait_request_o == rms_pkg::GAIT_PARK))
    else $error("startup cue without park into initializing");

  a_gait_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (walking_gait_o != 2'd0) |-> gait_request_o == rms_pkg::GAIT_WALK)
    else $error("gait index without walking request");

endmodule

bind robot_mode_supervisor rms_checker u_rms_checker (.*);

`default_nettype wire

FILE: test/robot_mode_supervisor_tb.sv
`timescale 1ns / 100ps

module robot_mode_supervisor_tb;
  import rms_pkg::*;

  localparam int unsigned GAIT_COUNT   = WALKING_GAITS_DEF;
  // index 3 has no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned SOAK_TICKS   = 70;
  localparam int unsigned PHASE_TICKS  = 90;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct {
    item_t   tick;
    bit      pinned;
    result_t res;
  } dir_row_t;

  // clock, reset and block ports
  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  item_t tick_d;
  logic out_valid;
  logic out_stall;
  logic [2:0] dut_mode;
  logic [2:0] dut_gait_request;
  logic [11:0] dut_gait_duration;
  logic [1:0] dut_walking_gait;
  logic dut_torque_off;
  logic [1:0] dut_sound_cue;
  logic dut_reset_params;

  // a directed row may carry a hand-written result; it travels with the tick
  logic pin_on;
  result_t pin_res;

  // tracked supervisor state, mirrors the block after every tick transfer
  logic [2:0] p_mode;
  logic [16:0] p_timer;
  cmd_t p_cmd;
  int unsigned p_gait;
  cfg_t p_cfg;

  result_t expected_results[$];
  dir_row_t dir_rows[$];

  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned ticks_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycles = 0;

  robot_mode_supervisor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .elapsed_ms_i       (tick_d.elapsed_ms),
    .power_switch_on_i  (tick_d.power_switch_on),
    .link_paired_i      (tick_d.link_paired),
    .data_age_ms_i      (tick_d.data_age_ms),
    .gait_ready_i       (tick_d.gait_ready),
    .all_torque_on_i    (tick_d.all_torque_on),
    .new_command_i      (tick_d.new_command),
    .button_left_i      (tick_d.button_left),
    .button_right_i     (tick_d.button_right),
    .mode_switches_i    (tick_d.mode_switches),
    .axes_active_i      (tick_d.axes_active),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .mode_o             (dut_mode),
    .gait_request_o     (dut_gait_request),
    .gait_duration_ms_o (dut_gait_duration),
    .walking_gait_o     (dut_walking_gait),
    .torque_off_o       (dut_torque_off),
    .sound_cue_o        (dut_sound_cue),
    .reset_gait_params_o(dut_reset_params)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // supervisor prediction
  // ---------------------------------------------------------------------------

  // mode change with its gait request; every change clears the timer
  function automatic void go_mode(input logic [2:0] m, input gait_req_e g,
                                  input logic [11:0] d, inout result_t r);
    r.gait_request     = g;
    r.gait_duration_ms = d;
    if (m == MODE_INIT) r.reset_gait_params = 1'b1;
    p_mode  = m;
    p_timer = '0;
  endfunction

  // link loss drops the latched command and goes back to initializing
  function automatic void drop_link(input bit park, inout result_t r);
    p_cmd = '0;
    if (park) go_mode(MODE_INIT, GAIT_PARK, PARK_MS, r);
    else go_mode(MODE_INIT, GAIT_NONE, '0, r);
  endfunction

  function automatic result_t predict_tick(input item_t t);
    result_t r;
    int unsigned dt;
    int unsigned tsum;
    logic bad_link;
    cmd_t c;
    r = '0;
    // long ticks are clamped, the timer sticks at its top
    dt = (t.elapsed_ms > MAX_TICK_MS) ? MAX_TICK_MS : t.elapsed_ms;
    tsum = p_timer + dt;
    p_timer = (tsum > TIMER_MAX) ? TIMER_MAX : tsum[16:0];
    if (p_gait >= GAIT_COUNT) p_gait = 0;
    if (t.new_command) begin
      p_cmd = '{axes: t.axes_active, balance: t.mode_switches[2], pose: t.mode_switches[1],
                adjust: t.mode_switches[0], right: t.button_right, left: t.button_left};
    end
    bad_link = !(t.link_paired && t.data_age_ms <= p_cfg.data_timeout_ms) ||
               !t.power_switch_on;
    c = p_cmd;
    case (p_mode)
      MODE_OFF: begin
        if (t.power_switch_on) begin
          r.sound_cue = SOUND_STARTUP;
          go_mode(MODE_INIT, GAIT_PARK, PARK_MS, r);
        end
      end
      MODE_INIT: begin
        if (t.gait_ready) begin
          if (!t.power_switch_on) begin
            r.torque_off = 1'b1;
            r.sound_cue  = SOUND_SHUTDOWN;
            go_mode(MODE_OFF, GAIT_NONE, '0, r);
          end else if (t.link_paired) begin
            if (t.all_torque_on) go_mode(MODE_READY, GAIT_NONE, '0, r);
            else go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
          end else if (p_timer > p_cfg.torque_off_wait_ms) begin
            p_timer = '0;
            r.torque_off = 1'b1;
          end
        end
      end
      MODE_READY: begin
        if (bad_link) begin
          drop_link(1'b0, r);
        end else if (c.left && t.gait_ready) begin
          p_cmd.left = 1'b0;
          go_mode(MODE_STAND, GAIT_STANDUP, STAND_PARKED_MS, r);
        end else if (p_timer > p_cfg.torque_off_wait_ms) begin
          p_timer = '0;
          r.torque_off = 1'b1;
        end
      end
      MODE_STAND: begin
        if (t.gait_ready) begin
          if (bad_link) drop_link(1'b1, r);
          else if (c.pose) go_mode(MODE_POSE, GAIT_POSING, '0, r);
          else if (c.balance) go_mode(MODE_LEVEL, GAIT_LEVEL, '0, r);
          else if (c.left) begin
            p_cmd.left = 1'b0;
            go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
          end else if (c.axes || c.right || c.adjust) begin
            go_mode(MODE_WALK, GAIT_WALK, '0, r);
          end else if (p_timer > {p_cfg.idle_timeout_ms, 1'b0}) begin
            // standing parks after twice the walking idle limit
            go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
          end
        end
      end
      MODE_LEVEL: begin
        if (t.gait_ready) begin
          if (bad_link) drop_link(1'b1, r);
          else if (c.left) begin
            p_cmd.left = 1'b0;
            go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
          end else if (c.pose) go_mode(MODE_POSE, GAIT_POSING, '0, r);
          else if (!c.balance) go_mode(MODE_STAND, GAIT_STANDUP, STAND_DEPLOYED_MS, r);
        end
      end
      MODE_POSE: begin
        if (t.gait_ready) begin
          if (bad_link) drop_link(1'b1, r);
          else if (c.left) begin
            p_cmd.left = 1'b0;
            go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
          end else if (!c.pose) go_mode(MODE_STAND, GAIT_STANDUP, STAND_DEPLOYED_MS, r);
        end
      end
      MODE_WALK: begin
        // stick activity keeps walking alive
        if (c.axes) p_timer = '0;
        if (bad_link) drop_link(1'b1, r);
        else if (c.left) begin
          p_cmd.left = 1'b0;
          go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
        end else if (c.right) begin
          // right press steps to the next walking gait, in place
          p_cmd.right = 1'b0;
          p_gait = (p_gait + 1 >= GAIT_COUNT) ? 0 : p_gait + 1;
          p_timer = '0;
          r.gait_request = GAIT_WALK;
        end else if (c.pose) go_mode(MODE_POSE, GAIT_POSING, '0, r);
        else if (c.balance) go_mode(MODE_LEVEL, GAIT_LEVEL, '0, r);
        else if (p_timer > p_cfg.idle_timeout_ms) begin
          go_mode(MODE_STAND, GAIT_STANDUP, STAND_DEPLOYED_MS, r);
        end
      end
      default: go_mode(MODE_READY, GAIT_PARK, PARK_MS, r);
    endcase
    r.mode = p_mode;
    if (r.gait_request == GAIT_WALK) r.walking_gait = p_gait[1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // transfer monitors
  // ---------------------------------------------------------------------------

  // every accepted tick advances the tracked state and queues one result
  always @(posedge clk_i) begin
    result_t predicted;
    if (rst_ni && in_valid && !in_stall) begin
      predicted = predict_tick(tick_d);
      expected_results.push_back(pin_on ? pin_res : predicted);
      ticks_taken++;
    end
  end

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", fname, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $error("result transfer with no tick pending");
      end else begin
        want = expected_results.pop_front();
        check_field("mode", want.mode, dut_mode);
        check_field("gait_request", want.gait_request, dut_gait_request);
        check_field("gait_duration_ms", want.gait_duration_ms, dut_gait_duration);
        check_field("walking_gait", want.walking_gait, dut_walking_gait);
        check_field("torque_off", want.torque_off, dut_torque_off);
        check_field("sound_cue", want.sound_cue, dut_sound_cue);
        check_field("reset_gait_params", want.reset_gait_params, dut_reset_params);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure: random bursts, plus one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic item_t tick_of(input logic [4:0] el, input logic sw, input logic pair,
                                    input logic [15:0] age, input logic rdy, input logic tq,
                                    input logic nc, input logic bl, input logic br,
                                    input logic [2:0] ms, input logic ax);
    item_t t;
    t = '{elapsed_ms: el, power_switch_on: sw, link_paired: pair, data_age_ms: age,
          gait_ready: rdy, all_torque_on: tq, new_command: nc, button_left: bl,
          button_right: br, mode_switches: ms, axes_active: ax};
    return t;
  endfunction

  function automatic result_t pinned_result(input logic [2:0] m, input gait_req_e g,
                                            input logic [11:0] d, input logic tq,
                                            input sound_e s, input logic rp);
    result_t r;
    r = '0;
    r.mode = m;
    r.gait_request = g;
    r.gait_duration_ms = d;
    r.torque_off = tq;
    r.sound_cue = s;
    r.reset_gait_params = rp;
    return r;
  endfunction

  task automatic add_row(input item_t t, input bit pinned = 1'b0, input result_t res = '0);
    dir_rows.push_back('{t, pinned, res});
  endtask

  // mostly healthy, powered, paired ticks so the mode machine gets past the parked modes
  function automatic item_t random_tick();
    item_t t;
    int unsigned lim;
    lim = p_cfg.data_timeout_ms;
    t.elapsed_ms = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(21, 31))
                                                : 5'($urandom_range(0, 20));
    t.power_switch_on = $urandom_range(0, 59) != 0;
    t.link_paired = $urandom_range(0, 49) != 0;
    case ($urandom_range(0, 29))
      0: t.data_age_ms = 16'($urandom);
      1: t.data_age_ms = (lim == 'hFFFF) ? 16'(lim) : 16'(lim + 1);
      2: t.data_age_ms = 16'(lim);
      default: t.data_age_ms = 16'($urandom_range(0, lim));
    endcase
    t.gait_ready = $urandom_range(0, 6) != 0;
    t.all_torque_on = $urandom_range(0, 3) != 0;
    t.new_command = $urandom_range(0, 2) == 0;
    t.button_left = $urandom_range(0, 4) == 0;
    t.button_right = $urandom_range(0, 3) == 0;
    t.mode_switches = {$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                       $urandom_range(0, 3) == 0};
    t.axes_active = $urandom_range(0, 2) == 0;
    return t;
  endfunction

  // offer one tick and hold it until the transfer
  task automatic offer_tick(input item_t t, input bit pinned, input result_t res);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    tick_d <= t;
    pin_on <= pinned;
    pin_res <= res;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // wait for every queued result plus the pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers back to back, then the unused index
  task automatic load_settings(input cfg_t s);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [15:0] val [4];
    idx = '{CFG_TORQUE_OFF_WAIT, CFG_IDLE_TIMEOUT, CFG_DATA_TIMEOUT, CFG_IDX_SPARE};
    val = '{s.torque_off_wait_ms, s.idle_timeout_ms, s.data_timeout_ms, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk_i);
      cfg_writes++;
    end
    cfg_we <= 1'b0;
    p_cfg = s;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_t s;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_TORQUE_OFF_WAIT;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    tick_d <= '0;
    pin_on <= 1'b0;
    pin_res <= '0;
    p_mode = MODE_OFF;
    p_timer = '0;
    p_cmd = '0;
    p_gait = 0;
    p_cfg = '{TORQUE_OFF_WAIT_RST, IDLE_TIMEOUT_RST, DATA_TIMEOUT_RST};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through every mode at the reset register values
    // off with the switch down stays put
    add_row(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_OFF, GAIT_NONE, '0, 0, SOUND_NONE, 0));
    // power on with a clamped long tick: startup sound, park, parameter reset
    add_row(tick_of(31, 1, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_INIT, GAIT_PARK, PARK_MS, 0, SOUND_STARTUP, 1));
    // gait engine busy: initializing waits
    add_row(tick_of(5, 1, 1, 0, 0, 1, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_INIT, GAIT_NONE, '0, 0, SOUND_NONE, 0));
    // switch off during initializing: torque off and shutdown sound
    add_row(tick_of(20, 0, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_OFF, GAIT_NONE, '0, 1, SOUND_SHUTDOWN, 0));
    add_row(tick_of(1, 1, 0, 0, 0, 0, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_INIT, GAIT_PARK, PARK_MS, 0, SOUND_STARTUP, 1));
    // paired with some servo limp: park on the way to ready
    add_row(tick_of(2, 1, 1, 0, 1, 0, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_READY, GAIT_PARK, PARK_MS, 0, SOUND_NONE, 0));
    // left press with command age right at the limit still counts as healthy
    add_row(tick_of(3, 1, 1, DATA_TIMEOUT_RST, 1, 1, 1, 1, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_STAND, GAIT_STANDUP, STAND_PARKED_MS, 0, SOUND_NONE, 0));
    add_row(tick_of(4, 1, 1, 0, 1, 1, 1, 0, 0, 3'b010, 0));   // posing
    add_row(tick_of(4, 1, 1, 0, 1, 1, 1, 0, 0, 3'b000, 0));   // back to standing
    add_row(tick_of(4, 1, 1, 0, 1, 1, 1, 0, 0, 3'b100, 0));   // levelled
    add_row(tick_of(4, 1, 1, 0, 1, 1, 1, 0, 0, 3'b110, 0));   // posing wins
    add_row(tick_of(4, 1, 1, 0, 1, 1, 1, 0, 0, 3'b000, 0));
    add_row(tick_of(4, 1, 1, 0, 1, 1, 1, 0, 0, 3'b000, 1));   // sticks start walking
    // three right presses step the gait index round and wrap it
    add_row(tick_of(6, 1, 1, 0, 1, 1, 1, 0, 1, 3'b000, 0));
    add_row(tick_of(6, 1, 1, 0, 1, 1, 1, 0, 1, 3'b000, 0));
    add_row(tick_of(6, 1, 1, 0, 1, 1, 1, 0, 1, 3'b000, 0));
    add_row(tick_of(6, 1, 1, 0, 1, 1, 1, 0, 0, 3'b101, 0));   // walking to levelled
    add_row(tick_of(6, 1, 1, 0, 1, 1, 1, 1, 0, 3'b000, 0));   // left parks
    // stale command data in ready: link loss without park
    add_row(tick_of(7, 1, 1, DATA_TIMEOUT_RST + 16'd1, 1, 1, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_INIT, GAIT_NONE, '0, 0, SOUND_NONE, 1));
    add_row(tick_of(8, 1, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0));
    add_row(tick_of(9, 1, 1, 0, 1, 1, 1, 1, 0, 3'b000, 0));
    add_row(tick_of(10, 1, 1, 0, 1, 1, 1, 0, 0, 3'b001, 0));  // adjust-gait starts walking
    // pairing lost while walking: park and back to initializing
    add_row(tick_of(11, 1, 0, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b1,
            pinned_result(MODE_INIT, GAIT_PARK, PARK_MS, 0, SOUND_NONE, 1));
    // command fields without the new-command flag are ignored
    add_row(tick_of(31, 1, 0, 16'hFFFF, 1, 1, 0, 1, 1, 3'b111, 1));
    add_row(tick_of(31, 1, 1, 16'hFFFF, 1, 1, 1, 0, 1, 3'b111, 1));
    foreach (dir_rows[i]) offer_tick(dir_rows[i].tick, dir_rows[i].pinned, dir_rows[i].res);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: s = '{16'd0, 16'd0, 16'd0};
        1: s = '{16'($urandom_range(0, 400)), 16'($urandom_range(0, 300)),
                 16'($urandom_range(0, 600))};
        2: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        3: s = '{16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)), 16'($urandom)};
        default: s = '{TORQUE_OFF_WAIT_RST, IDLE_TIMEOUT_RST, DATA_TIMEOUT_RST};
      endcase
      load_settings(s);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        // idling comes and goes in stretches; the last phase runs flat out
        if (k % 30 == 0) begin
          src_idle_on = (ph < 4) && ($urandom_range(0, 3) != 0);
          sink_idle_on = (ph < 4) && ($urandom_range(0, 3) != 0);
        end
        // long result hold while ticks keep coming, fills the block up
        if (ph == 1 && k == 40) begin
          hold_req = 1'b1;
          src_idle_on = 1'b0;
        end
        offer_tick(random_tick(), 1'b0, '0);
      end
    end

    // timer soak: park in standing with the engine busy over a run of clamped long ticks;
    // the idle park fires only once the summed time passes twice the idle limit
    drain();
    load_settings('{16'hFFFF, 16'd600, 16'hFFFF});
    offer_tick(tick_of(0, 0, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b0, '0);
    offer_tick(tick_of(0, 0, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b0, '0);
    offer_tick(tick_of(0, 1, 1, 0, 0, 1, 0, 0, 0, 3'b000, 0), 1'b0, '0);
    offer_tick(tick_of(0, 1, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b0, '0);
    offer_tick(tick_of(0, 1, 1, 0, 1, 1, 1, 1, 0, 3'b000, 0), 1'b0, '0);
    for (int k = 0; k < SOAK_TICKS; k++) begin
      offer_tick(tick_of(5'($urandom_range(20, 31)), 1, 1, 16'($urandom), 0, 1, 0, 0, 0,
                         3'b000, 0), 1'b0, '0);
    end
    offer_tick(tick_of(0, 1, 1, 0, 1, 1, 0, 0, 0, 3'b000, 0), 1'b0, '0);

    drain();
    $display("run: %0d ticks (directed walk, five register settings, a %0d-cycle result hold,",
             ticks_taken, HOLD_CYCLES);
    $display("     a %0d-tick timer soak), %0d config writes, %0d results, %0d mismatches",
             SOAK_TICKS, cfg_writes, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rms_pkg.sv
rtl/rms_cfg_regs.sv
rtl/rms_in_stage.sv
rtl/rms_core.sv
rtl/robot_mode_supervisor.sv
rtl/rms_checker.sv
test/robot_mode_supervisor_tb.sv
